/* hw/rtl/link_loss_delay_impairment_defines.svh */
// ----------------------------------------------------------------------------
// link loss/delay impairment assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef LINK_LOSS_DELAY_IMPAIRMENT_DEFINES_SVH
`define LINK_LOSS_DELAY_IMPAIRMENT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LLIM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llim check failed");

// next-cycle implication, sampled on clk, off while in reset
`define LLIM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llim check failed");

`endif

/* hw/rtl/llim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llim_pkg
// shared widths, codes and constants of the link impairment engine
// ----------------------------------------------------------------------------
package llim_pkg;

    // field widths
    localparam int OPCODE_W    = 1;
    localparam int DIR_W       = 1;
    localparam int COUNT_W     = 17;
    localparam int NOW_W       = 40;
    localparam int VERDICT_W   = 2;
    localparam int DUE_W       = 41;
    localparam int BYTES_W     = 32;
    localparam int LOSS_W      = 7;
    localparam int LATENCY_W   = 16;
    localparam int JITTER_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // generator
    localparam int          RNG_W        = 64;
    localparam logic [63:0] DEFAULT_SEED = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] STAR_MULT    = 64'h2545_F491_4F6C_DD1D;
    localparam int          XS_SHIFT_A   = 12;
    localparam int          XS_SHIFT_B   = 25;
    localparam int          XS_SHIFT_C   = 27;

    // multiplier digits and remainder radix
    localparam int MUL_DIGIT_W = 16;
    localparam int MUL_STEPS   = RNG_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int MOD_RADIX   = 2;
    localparam int MOD_STEPS   = RNG_W / MOD_RADIX;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);
    localparam int DIVISOR_W   = JITTER_W + 1;

    localparam logic [DIVISOR_W-1:0] PERCENT_DIV = DIVISOR_W'(100);

    // result codes
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_QUEUED = 2'd0,
        VERDICT_LOST   = 2'd1,
        VERDICT_OVF    = 2'd2,
        VERDICT_SENT   = 2'd3
    } llim_verdict_t;

    // item codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_ARRIVAL = 1'b0,
        OP_SENT    = 1'b1
    } llim_opcode_t;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOSS    = 3'd0,
        CFG_LATENCY = 3'd1,
        CFG_JITTER  = 3'd2,
        CFG_BUDGET  = 3'd3,
        CFG_SEED    = 3'd4
    } llim_cfg_index_t;

    localparam logic [BYTES_W-1:0] BUDGET_RESET = BYTES_W'(1048576);

    // generator controls
    typedef struct packed {
        logic start;
        logic load;
    } llim_rng_ctrl_t;

    // remainder unit controls
    typedef struct packed {
        logic                 start;
        logic [DIVISOR_W-1:0] divisor;
    } llim_mod_ctrl_t;

endpackage

/* hw/rtl/link_loss_delay_impairment.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_loss_delay_impairment
// loss, budget and delay decisions for the two directions of a relay link
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_ready is high only while the sequencer
// is idle. A sent report passes the dispatch state and then the done state;
// an arrival that needs no random draw passes dispatch, the budget check and
// done. Each draw (the loss decision when the loss register is nonzero, the
// jitter when the jitter register is nonzero) runs the generator for the
// xorshift step, four 64x16 digit steps of the multiplier and its done flag,
// then the remainder unit for its 32 steps of two quotient bits each and its
// done flag. The result sits in an output register; the next item is taken
// while it waits for out_ready.
module link_loss_delay_impairment (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [llim_pkg::OPCODE_W-1:0]     opcode,
    input  logic [llim_pkg::DIR_W-1:0]        direction,
    input  logic [llim_pkg::COUNT_W-1:0]      byte_count,
    input  logic [llim_pkg::NOW_W-1:0]        now_ms,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [llim_pkg::VERDICT_W-1:0]    verdict,
    output logic [llim_pkg::DUE_W-1:0]        due_ms,
    output logic [llim_pkg::BYTES_W-1:0]      queued_bytes,
    // configuration
    input  logic                              cfg_write,
    input  logic [llim_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [llim_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import llim_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DISPATCH = 8'b0000_0010,
        ST_LOSS_RNG = 8'b0000_0100,
        ST_LOSS_MOD = 8'b0000_1000,
        ST_BUDGET   = 8'b0001_0000,
        ST_JIT_RNG  = 8'b0010_0000,
        ST_JIT_MOD  = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } llim_state_t;

    llim_state_t state_reg, state_next;

    // configuration
    logic [LOSS_W-1:0]    loss_reg, loss_next;
    logic [LATENCY_W-1:0] latency_reg, latency_next;
    logic [JITTER_W-1:0]  jitter_reg, jitter_next;
    logic [BYTES_W-1:0]   budget_reg, budget_next;

    // per-direction byte counters
    logic [BYTES_W-1:0] down_reg, down_next;
    logic [BYTES_W-1:0] up_reg, up_next;

    // captured item
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [DIR_W-1:0]    dir_reg, dir_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [NOW_W-1:0]    now_reg, now_next;

    // result being built
    logic [VERDICT_W-1:0] res_verdict_reg, res_verdict_next;
    logic [DUE_W-1:0]     res_due_reg, res_due_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic [DUE_W-1:0]     due_ms_reg, due_ms_next;
    logic [BYTES_W-1:0]   queued_bytes_reg, queued_bytes_next;

    // shared units
    llim_rng_ctrl_t       rng_ctrl;
    logic                 rng_start;
    logic                 seed_load;
    logic                 rng_done;
    logic [RNG_W-1:0]     rng_product;
    llim_mod_ctrl_t       mod_ctrl;
    logic                 mod_done;
    logic [DIVISOR_W-1:0] mod_rem;

    // datapath helpers
    logic [BYTES_W-1:0] cur_bytes;
    logic [BYTES_W-1:0] used_bytes;
    logic [BYTES_W-1:0] room_bytes;
    logic [BYTES_W-1:0] count_ext;
    logic [BYTES_W:0]   sum_bytes;
    logic [DUE_W-1:0]   base_due;

    assign cur_bytes  = (dir_reg != '0) ? up_reg : down_reg;
    assign count_ext  = BYTES_W'(count_reg);
    // a budget lowered below the counter leaves no room
    assign used_bytes = (cur_bytes < budget_reg) ? cur_bytes : budget_reg;
    assign room_bytes = budget_reg - used_bytes;
    assign sum_bytes  = {1'b0, cur_bytes} + {1'b0, count_ext};
    assign base_due   = DUE_W'(now_reg) + DUE_W'(latency_reg);

    assign in_ready = (state_reg == ST_IDLE);

    // generator controls from the sequencer and the register port
    assign rng_ctrl = '{start: rng_start, load: seed_load};

    llim_rng u_rng (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (rng_ctrl),
        .load_value (cfg_data),
        .done       (rng_done),
        .product    (rng_product)
    );

    llim_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mod_ctrl),
        .dividend  (rng_product),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // configuration writes, only issued while idle by the user; the block has no check for it
    always_comb
    begin
        loss_next     = loss_reg;
        latency_next  = latency_reg;
        jitter_next   = jitter_reg;
        budget_next   = budget_reg;
        seed_load     = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LOSS:    loss_next     = cfg_data[LOSS_W-1:0];
                CFG_LATENCY: latency_next  = cfg_data[LATENCY_W-1:0];
                CFG_JITTER:  jitter_next   = cfg_data[JITTER_W-1:0];
                CFG_BUDGET:  budget_next   = cfg_data[BYTES_W-1:0];
                // seed write reloads the generator at once
                CFG_SEED:    seed_load     = 1'b1;
                default:     ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        down_next         = down_reg;
        up_next           = up_reg;
        op_next           = op_reg;
        dir_next          = dir_reg;
        count_next        = count_reg;
        now_next          = now_reg;
        res_verdict_next  = res_verdict_reg;
        res_due_next      = res_due_reg;
        out_valid_next    = out_valid_reg;
        verdict_next      = verdict_reg;
        due_ms_next       = due_ms_reg;
        queued_bytes_next = queued_bytes_reg;
        rng_start         = 1'b0;
        mod_ctrl.start    = 1'b0;
        mod_ctrl.divisor  = PERCENT_DIV;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    dir_next   = direction;
                    count_next = byte_count;
                    now_next   = now_ms;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (op_reg == OP_SENT)
                begin
                    // sent report, counter saturates at zero
                    if (dir_reg != '0)
                    begin
                        up_next = (count_ext >= cur_bytes) ? '0 : cur_bytes - count_ext;
                    end
                    else
                    begin
                        down_next = (count_ext >= cur_bytes) ? '0 : cur_bytes - count_ext;
                    end
                    res_verdict_next = VERDICT_SENT;
                    res_due_next     = '0;
                    state_next       = ST_DONE;
                end
                else if (loss_reg != '0)
                begin
                    rng_start  = 1'b1;
                    state_next = ST_LOSS_RNG;
                end
                else
                begin
                    state_next = ST_BUDGET;
                end
            end
            ST_LOSS_RNG:
            begin
                if (rng_done)
                begin
                    mod_ctrl.start   = 1'b1;
                    mod_ctrl.divisor = PERCENT_DIV;
                    state_next       = ST_LOSS_MOD;
                end
            end
            ST_LOSS_MOD:
            begin
                if (mod_done)
                begin
                    if (mod_rem < DIVISOR_W'(loss_reg))
                    begin
                        // lost chunk resets the link
                        down_next        = '0;
                        up_next          = '0;
                        res_verdict_next = VERDICT_LOST;
                        res_due_next     = '0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_BUDGET;
                    end
                end
            end
            ST_BUDGET:
            begin
                if (count_ext > room_bytes)
                begin
                    // over budget resets the link
                    down_next        = '0;
                    up_next          = '0;
                    res_verdict_next = VERDICT_OVF;
                    res_due_next     = '0;
                    state_next       = ST_DONE;
                end
                else
                begin
                    if (dir_reg != '0)
                    begin
                        up_next = sum_bytes[BYTES_W-1:0];
                    end
                    else
                    begin
                        down_next = sum_bytes[BYTES_W-1:0];
                    end
                    res_verdict_next = VERDICT_QUEUED;
                    if (jitter_reg != '0)
                    begin
                        rng_start  = 1'b1;
                        state_next = ST_JIT_RNG;
                    end
                    else
                    begin
                        res_due_next = base_due;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_JIT_RNG:
            begin
                if (rng_done)
                begin
                    mod_ctrl.start   = 1'b1;
                    mod_ctrl.divisor = DIVISOR_W'(jitter_reg) + 1'b1;
                    state_next       = ST_JIT_MOD;
                end
            end
            ST_JIT_MOD:
            begin
                if (mod_done)
                begin
                    res_due_next = base_due + DUE_W'(mod_rem);
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    verdict_next      = res_verdict_reg;
                    due_ms_next       = res_due_reg;
                    queued_bytes_next = cur_bytes;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loss_reg      <= '0;
            latency_reg   <= '0;
            jitter_reg    <= '0;
            budget_reg    <= BUDGET_RESET;
            down_reg      <= '0;
            up_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loss_reg      <= loss_next;
            latency_reg   <= latency_next;
            jitter_reg    <= jitter_next;
            budget_reg    <= budget_next;
            down_reg      <= down_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        dir_reg          <= dir_next;
        count_reg        <= count_next;
        now_reg          <= now_next;
        res_verdict_reg  <= res_verdict_next;
        res_due_reg      <= res_due_next;
        verdict_reg      <= verdict_next;
        due_ms_reg       <= due_ms_next;
        queued_bytes_reg <= queued_bytes_next;
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = verdict_reg;
    assign due_ms       = due_ms_reg;
    assign queued_bytes = queued_bytes_reg;

endmodule

/* hw/rtl/llim_rng.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llim_rng
// xorshift64* generator with a four-step 64x16 digit multiplier
// ----------------------------------------------------------------------------
module llim_rng (
    input  logic                          clk,
    input  logic                          rst_n,
    input  llim_pkg::llim_rng_ctrl_t      ctrl,
    input  logic [llim_pkg::RNG_W-1:0]    load_value,
    output logic                          done,
    output logic [llim_pkg::RNG_W-1:0]    product
);
    import llim_pkg::*;

    logic [RNG_W-1:0]     state_reg, state_next;
    logic [RNG_W-1:0]     a_reg, a_next;
    logic [RNG_W-1:0]     b_reg, b_next;
    logic [RNG_W-1:0]     acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [RNG_W-1:0] xs1, xs2, xs3;
    logic [RNG_W-1:0] partial;

    assign xs1     = state_reg ^ (state_reg >> XS_SHIFT_A);
    assign xs2     = xs1 ^ (xs1 << XS_SHIFT_B);
    assign xs3     = xs2 ^ (xs2 >> XS_SHIFT_C);
    assign partial = a_reg * RNG_W'(b_reg[MUL_DIGIT_W-1:0]);

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.load)
        begin
            state_next = (load_value == '0) ? DEFAULT_SEED : load_value;
        end
        else if (ctrl.start)
        begin
            state_next = xs3;
            a_next     = xs3;
            b_next     = STAR_MULT;
            acc_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + partial;
            a_next   = a_reg << MUL_DIGIT_W;
            b_next   = b_reg >> MUL_DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DEFAULT_SEED;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* hw/rtl/llim_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llim_mod
// restoring remainder of a 64-bit value by a 17-bit divisor, two bits a cycle
// ----------------------------------------------------------------------------
module llim_mod (
    input  logic                            clk,
    input  logic                            rst_n,
    input  llim_pkg::llim_mod_ctrl_t        ctrl,
    input  logic [llim_pkg::RNG_W-1:0]      dividend,
    output logic                            done,
    output logic [llim_pkg::DIVISOR_W-1:0]  remainder
);
    import llim_pkg::*;

    logic [RNG_W-1:0]     dividend_reg, dividend_next;
    logic [DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIVISOR_W-1:0] rem_step;
    logic [DIVISOR_W:0]   trial;

    always_comb
    begin
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        rem_step      = rem_reg;
        trial         = '0;
        if (ctrl.start)
        begin
            dividend_next = dividend;
            divisor_next  = ctrl.divisor;
            rem_next      = '0;
            cnt_next      = '0;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it never needs the top bit
            for (int i = 0; i < MOD_RADIX; i++)
            begin
                trial = {rem_step, dividend_reg[RNG_W-1-i]};
                if (trial >= {1'b0, divisor_reg})
                begin
                    trial = trial - {1'b0, divisor_reg};
                end
                rem_step = trial[DIVISOR_W-1:0];
            end
            rem_next      = rem_step;
            dividend_next = dividend_reg << MOD_RADIX;
            cnt_next      = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/llim_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llim_checker
// port-level checks of the link impairment engine, bound to the top level
// ----------------------------------------------------------------------------
`include "link_loss_delay_impairment_defines.svh"

module llim_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [llim_pkg::VERDICT_W-1:0]    verdict,
    input  logic [llim_pkg::DUE_W-1:0]        due_ms,
    input  logic [llim_pkg::BYTES_W-1:0]      queued_bytes
);
    import llim_pkg::*;

    // stalled result holds
    `LLIM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(verdict) && $stable(due_ms) && $stable(queued_bytes))

    // only a queued chunk carries a due time
    `LLIM_ASSERT_NOW(a_due_zero, out_valid && (verdict != VERDICT_QUEUED), due_ms == '0)

    // link reset leaves the counter empty
    `LLIM_ASSERT_NOW(a_reset_empty, out_valid && ((verdict == VERDICT_LOST) || (verdict == VERDICT_OVF)), queued_bytes == '0)

    // one item at a time
    `LLIM_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule

bind link_loss_delay_impairment llim_checker u_llim_checker (.*);
